@@ rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the periodic timer table: item kinds,
// controller states, command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // Default table depth
    localparam int TIMERS_DEF = 16;

    // Field widths
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 64;
    localparam int SERVICE_W  = 16;
    localparam int INTERVAL_W = 31;
    localparam int TIMEOUT_W  = 32;

    // Packed stream widths (zero-filled to whole bytes)
    localparam int S_DATA_W = 112;  // now, service, interval = 111 bits
    localparam int M_DATA_W = 56;   // status, timeout, fired, service = 50 bits

    // Item kinds; the fourth code is ignored
    localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd2;

    // Query answers
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX  = 32'h7FFF_FFFF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_NONE = 32'hFFFF_FFFF;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REG,
        ST_SCAN,
        ST_FLUSH
    } ptt_state_t;

    // Output register load select
    typedef enum logic [1:0] {
        OUT_NONE,   // keep output register
        OUT_REG,    // answer a register request
        OUT_PUSH,   // emit the held fired entry, more may follow
        OUT_FINAL   // emit the closing result of a query or dispatch
    } ptt_out_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic         latch;       // capture the accepted request
        logic         rd_en;       // read the entry at rd_addr
        logic         scan_step;   // consume the entry held in the read registers
        logic         scan_first;  // that entry is entry zero
        logic         wr_reg;      // append a new timer
        ptt_out_sel_t out_sel;
    } ptt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic              out_free;    // output register can take a result
        logic              due_hit;     // entry in the read registers is due
        logic              pend_valid;  // a fired entry is held back
        logic [KIND_W-1:0] kind;        // kind of the request in work
    } ptt_status_t;

endpackage

@@ rtl/ptt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptt_ctrl
// Controller: accepts requests, walks the table one entry per cycle for
// queries and dispatches unless a dispatch stalls, and sequences the result loads.
// ----------------------------------------------------------------------------
module ptt_ctrl #(
    parameter int TIMERS = ptt_pkg::TIMERS_DEF,
    parameter int IW     = (TIMERS > 1) ? $clog2(TIMERS) : 1,
    parameter int CW     = $clog2(TIMERS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic [ptt_pkg::KIND_W-1:0] in_kind,
    output logic                       in_ready,
    input  logic [CW-1:0]              count,
    input  ptt_pkg::ptt_status_t       stat,
    output ptt_pkg::ptt_cmd_t          cmd,
    output logic [IW-1:0]              rd_addr,
    output logic [IW-1:0]              wr_addr
);
    import ptt_pkg::*;

    ptt_state_t    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          last_entry;
    logic          fire_now;

    // Hold state and scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign last_entry = ((CW'(idx_reg) + CW'(1)) == count);
    assign fire_now   = (stat.kind == KIND_DISPATCH) && stat.due_hit;
    assign wr_addr    = idx_reg;

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        in_ready       = 1'b0;
        rd_addr        = '0;
        cmd.latch      = 1'b0;
        cmd.rd_en      = 1'b0;
        cmd.scan_step  = 1'b0;
        cmd.scan_first = 1'b0;
        cmd.wr_reg     = 1'b0;
        cmd.out_sel    = OUT_NONE;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch = 1'b1;
                    case (in_kind)
                        KIND_REGISTER: state_next = ST_REG;
                        KIND_QUERY, KIND_DISPATCH: begin
                            if (count == '0) begin
                                state_next = ST_FLUSH;
                            end else begin
                                cmd.rd_en  = 1'b1;
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_REG: begin
                if (stat.out_free) begin
                    cmd.wr_reg  = 1'b1;
                    cmd.out_sel = OUT_REG;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // Stall only when a second fired entry meets a full output
                if (!(fire_now && stat.pend_valid && !stat.out_free)) begin
                    cmd.scan_step  = 1'b1;
                    cmd.scan_first = (idx_reg == '0);
                    if (fire_now && stat.pend_valid) begin
                        cmd.out_sel = OUT_PUSH;
                    end
                    if (last_entry) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_reg + IW'(1);
                        idx_next  = idx_reg + IW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (stat.out_free) begin
                    cmd.out_sel = OUT_FINAL;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/ptt_dpath.sv @@
// ----------------------------------------------------------------------------
// ptt_dpath
// Datapath: timer memories, request registers, running minimum, held fired
// entry and the result register.
// ----------------------------------------------------------------------------
module ptt_dpath #(
    parameter int TIMERS = ptt_pkg::TIMERS_DEF,
    parameter int IW     = (TIMERS > 1) ? $clog2(TIMERS) : 1,
    parameter int CW     = $clog2(TIMERS + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ptt_pkg::KIND_W-1:0]     in_kind,
    input  logic [ptt_pkg::TIME_W-1:0]     in_now,
    input  logic [ptt_pkg::SERVICE_W-1:0]  in_service,
    input  logic [ptt_pkg::INTERVAL_W-1:0] in_interval,
    input  ptt_pkg::ptt_cmd_t              cmd,
    input  logic [IW-1:0]                  rd_addr,
    input  logic [IW-1:0]                  wr_addr,
    output ptt_pkg::ptt_status_t           stat,
    output logic [CW-1:0]                  count,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           out_status,
    output logic [ptt_pkg::TIMEOUT_W-1:0]  out_timeout,
    output logic                           out_fired,
    output logic [ptt_pkg::SERVICE_W-1:0]  out_service,
    output logic                           out_last
);
    import ptt_pkg::*;

    // Timer memories
    logic [SERVICE_W-1:0]  mem_service  [TIMERS];
    logic [INTERVAL_W-1:0] mem_interval [TIMERS];
    logic [TIME_W-1:0]     mem_due      [TIMERS];

    // Read data registers
    logic [SERVICE_W-1:0]  rd_service_reg;
    logic [INTERVAL_W-1:0] rd_interval_reg;
    logic [TIME_W-1:0]     rd_due_reg;

    // Request registers
    logic [KIND_W-1:0]     kind_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [SERVICE_W-1:0]  service_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    // Table state
    logic [CW-1:0]         count_reg;
    logic [TIME_W-1:0]     last_time_reg;
    logic [TIME_W-1:0]     best_reg;
    logic                  pend_valid_reg;
    logic [SERVICE_W-1:0]  pend_service_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  out_status_reg;
    logic [TIMEOUT_W-1:0]  out_timeout_reg;
    logic                  out_fired_reg;
    logic [SERVICE_W-1:0]  out_service_reg;
    logic                  out_last_reg;

    logic                  table_full;
    logic                  due_hit;
    logic                  out_free;
    logic                  due_wr_en;
    logic [IW-1:0]         due_wr_addr;
    logic [TIME_W-1:0]     due_wr_data;
    logic [TIME_W:0]       wait_diff;
    logic [TIMEOUT_W-1:0]  wait_ms;

    assign table_full = (count_reg == CW'(TIMERS));
    assign due_hit    = (rd_due_reg <= now_reg);
    assign out_free   = !out_valid_reg || out_ready;

    assign stat.out_free   = out_free;
    assign stat.due_hit    = due_hit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.kind       = kind_reg;
    assign count           = count_reg;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg     <= in_kind;
            now_reg      <= in_now;
            service_reg  <= in_service;
            interval_reg <= in_interval;
        end
    end

    // Count and last seen time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            last_time_reg <= '0;
        end else begin
            if (cmd.latch && (in_kind == KIND_QUERY || in_kind == KIND_DISPATCH)) begin
                last_time_reg <= in_now;
            end
            if (cmd.wr_reg && !table_full) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Append service and interval
    always_ff @(posedge aclk) begin
        if (cmd.wr_reg && !table_full) begin
            mem_service[count_reg[IW-1:0]]  <= service_reg;
            mem_interval[count_reg[IW-1:0]] <= interval_reg;
        end
    end

    // Due time write: new timer or advance of a fired one
    always_comb begin
        due_wr_en   = 1'b0;
        due_wr_addr = wr_addr;
        due_wr_data = rd_due_reg + {{(TIME_W-INTERVAL_W){1'b0}}, rd_interval_reg};
        if (cmd.wr_reg && !table_full) begin
            due_wr_en   = 1'b1;
            due_wr_addr = count_reg[IW-1:0];
            due_wr_data = last_time_reg + {{(TIME_W-INTERVAL_W){1'b0}}, interval_reg};
        end else if (cmd.scan_step && kind_reg == KIND_DISPATCH && due_hit) begin
            due_wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (due_wr_en) begin
            mem_due[due_wr_addr] <= due_wr_data;
        end
    end

    // Registered entry read
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_service_reg  <= mem_service[rd_addr];
            rd_interval_reg <= mem_interval[rd_addr];
            rd_due_reg      <= mem_due[rd_addr];
        end
    end

    // Running minimum of due times
    always_ff @(posedge aclk) begin
        if (cmd.scan_step && (cmd.scan_first || rd_due_reg < best_reg)) begin
            best_reg <= rd_due_reg;
        end
    end

    // Hold back the latest fired entry until the next one or the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.out_sel == OUT_FINAL) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.scan_step && kind_reg == KIND_DISPATCH && due_hit) begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && kind_reg == KIND_DISPATCH && due_hit) begin
            pend_service_reg <= rd_service_reg;
        end
    end

    // Time to the earliest due entry, clamped to zero and saturated
    assign wait_diff = {1'b0, best_reg} - {1'b0, now_reg};
    always_comb begin
        if (wait_diff[TIME_W]) begin
            wait_ms = '0;
        end else if (wait_diff[TIME_W-1:TIMEOUT_W-1] != '0) begin
            wait_ms = TIMEOUT_MAX;
        end else begin
            wait_ms = {1'b0, wait_diff[TIMEOUT_W-2:0]};
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_sel != OUT_NONE) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        case (cmd.out_sel)
            OUT_REG: begin
                out_status_reg  <= table_full;
                out_timeout_reg <= '0;
                out_fired_reg   <= 1'b0;
                out_service_reg <= '0;
                out_last_reg    <= 1'b1;
            end
            OUT_PUSH: begin
                out_status_reg  <= 1'b0;
                out_timeout_reg <= '0;
                out_fired_reg   <= 1'b1;
                out_service_reg <= pend_service_reg;
                out_last_reg    <= 1'b0;
            end
            OUT_FINAL: begin
                out_status_reg <= 1'b0;
                out_last_reg   <= 1'b1;
                if (kind_reg == KIND_QUERY) begin
                    out_timeout_reg <= (count_reg == '0) ? TIMEOUT_NONE : wait_ms;
                    out_fired_reg   <= 1'b0;
                    out_service_reg <= '0;
                end else begin
                    out_timeout_reg <= '0;
                    out_fired_reg   <= pend_valid_reg;
                    out_service_reg <= pend_valid_reg ? pend_service_reg : '0;
                end
            end
            default: begin
                out_status_reg <= out_status_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_timeout = out_timeout_reg;
    assign out_fired   = out_fired_reg;
    assign out_service = out_service_reg;
    assign out_last    = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TIMERS))
        else $error("timer count above table depth");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |-> (cmd.out_sel == OUT_NONE))
        else $error("result register loaded while a result waits");

    a_push_needs_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_sel == OUT_PUSH) |-> pend_valid_reg)
        else $error("fired result pushed with nothing held");

    a_append_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_reg && !table_full) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not advance the count");
`endif

endmodule

@@ rtl/periodic_timer_table_unit.sv @@
// A new request is taken only in idle, once the previous one has loaded its final result.
// The table walk reads one entry per cycle from the timer memories while it does not stall.
// A dispatch waits whenever a second due entry meets a result not yet taken.
// Reset clears the count, last seen time and control; timer memories are not
// cleared, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// periodic_timer_table_unit
// Table of periodic timers: register, query next timeout, dispatch due timers.
// ----------------------------------------------------------------------------
module periodic_timer_table_unit #(
    parameter int TIMERS = ptt_pkg::TIMERS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ptt_pkg::S_DATA_W-1:0]  s_tdata,  // now_ms, service_id, interval_ms
    input  logic [ptt_pkg::KIND_W-1:0]    s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ptt_pkg::M_DATA_W-1:0]  m_tdata,  // status, timeout_ms, fired, fired_service
    output logic                          m_tlast   // last
);
    import ptt_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);

    ptt_cmd_t             cmd;
    ptt_status_t          stat;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        wr_addr;
    logic [CW-1:0]        count;
    logic                 out_status;
    logic [TIMEOUT_W-1:0] out_timeout;
    logic                 out_fired;
    logic [SERVICE_W-1:0] out_service;

    ptt_ctrl #(
        .TIMERS (TIMERS),
        .IW     (IW),
        .CW     (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .count    (count),
        .stat     (stat),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    ptt_dpath #(
        .TIMERS (TIMERS),
        .IW     (IW),
        .CW     (CW)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_kind     (s_tuser),
        .in_now      (s_tdata[TIME_W-1:0]),
        .in_service  (s_tdata[TIME_W+SERVICE_W-1:TIME_W]),
        .in_interval (s_tdata[TIME_W+SERVICE_W+INTERVAL_W-1:TIME_W+SERVICE_W]),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .stat        (stat),
        .count       (count),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_timeout (out_timeout),
        .out_fired   (out_fired),
        .out_service (out_service),
        .out_last    (m_tlast)
    );

    // Pack the result, zero fill to the byte boundary
    assign m_tdata = {6'd0, out_service, out_fired, out_timeout, out_status};

endmodule

@@ test/tb_periodic_timer_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_periodic_timer_table_unit
// Self-checking bench for the periodic timer table. Register, query, dispatch
// and ignored-kind requests are streamed in with random gaps and random result
// backpressure. A behavioral model of the timer table predicts every answer,
// and each answer is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_periodic_timer_table_unit;

    import ptt_pkg::*;

    localparam int          TIMERS       = TIMERS_DEF;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          RANDOM_ITEMS = 160;
    localparam logic [1:0]  KIND_IGNORED = 2'd3;
    localparam logic [63:0] TIME_TOP     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TIME_HIGH    = 64'h0000_0100_0000_0000;
    localparam logic [30:0] IVL_TOP      = 31'h7FFF_FFFF;

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [TIME_W-1:0]     now_ms;
        logic [SERVICE_W-1:0]  service_id;
        logic [INTERVAL_W-1:0] interval_ms;
    } timer_req_t;

    typedef struct {
        logic                 status;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic                 fired;
        logic [SERVICE_W-1:0] fired_service;
        logic                 last;
    } timer_answer_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;  // now_ms, service_id, interval_ms
    logic [KIND_W-1:0]     s_tuser  = '0;  // kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;        // status, timeout_ms, fired, fired_service
    logic                  m_tlast;        // last

    // Request backlog and predicted answers
    timer_req_t    timer_req_q[$];
    timer_answer_t timer_answer_q[$];
    timer_req_t    drv_req;

    // Shadow copy of the timer table
    logic [SERVICE_W-1:0]  svc_tab [TIMERS];
    logic [INTERVAL_W-1:0] ivl_tab [TIMERS];
    logic [TIME_W-1:0]     due_tab [TIMERS];
    int                    tab_cnt   = 0;
    logic [TIME_W-1:0]     seen_time = '0;

    int fail_cnt  = 0;
    int cycle_cnt = 0;
    bit s_taken   = 1'b0;
    int s_gap     = 0;
    bit s_burst   = 1'b0;
    int m_stall   = 0;
    bit m_burst   = 1'b0;

    periodic_timer_table_unit #(.TIMERS(TIMERS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic timer_answer_t make_answer(logic status, logic [31:0] timeout,
                                                  logic fired, logic [15:0] service,
                                                  logic last);
        timer_answer_t a;
        a.status        = status;
        a.timeout_ms    = timeout;
        a.fired         = fired;
        a.fired_service = service;
        a.last          = last;
        return a;
    endfunction

    // Apply one request to the shadow table and queue the answers it causes
    task automatic timer_table_step(input timer_req_t rq);
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] wait_ms;
        timer_answer_t     tail;
        int                hits;
        hits = 0;
        case (rq.kind)
            KIND_REGISTER: begin
                if (tab_cnt >= TIMERS) begin
                    timer_answer_q.push_back(make_answer(1'b1, '0, 1'b0, '0, 1'b1));
                end else begin
                    svc_tab[tab_cnt] = rq.service_id;
                    ivl_tab[tab_cnt] = rq.interval_ms;
                    due_tab[tab_cnt] = seen_time + {33'b0, rq.interval_ms};
                    tab_cnt++;
                    timer_answer_q.push_back(make_answer(1'b0, '0, 1'b0, '0, 1'b1));
                end
            end
            KIND_QUERY: begin
                seen_time = rq.now_ms;
                if (tab_cnt == 0) begin
                    timer_answer_q.push_back(make_answer(1'b0, TIMEOUT_NONE, 1'b0, '0, 1'b1));
                end else begin
                    best = due_tab[0];
                    for (int i = 1; i < tab_cnt; i++) begin
                        if (due_tab[i] < best) best = due_tab[i];
                    end
                    wait_ms = (best > rq.now_ms) ? best - rq.now_ms : '0;
                    if (wait_ms > {32'b0, TIMEOUT_MAX}) wait_ms = {32'b0, TIMEOUT_MAX};
                    timer_answer_q.push_back(make_answer(1'b0, wait_ms[31:0], 1'b0, '0, 1'b1));
                end
            end
            KIND_DISPATCH: begin
                seen_time = rq.now_ms;
                for (int i = 0; i < tab_cnt; i++) begin
                    if (due_tab[i] <= rq.now_ms) begin
                        timer_answer_q.push_back(make_answer(1'b0, '0, 1'b1, svc_tab[i], 1'b0));
                        due_tab[i] = due_tab[i] + {33'b0, ivl_tab[i]};
                        hits++;
                    end
                end
                if (hits == 0) begin
                    timer_answer_q.push_back(make_answer(1'b0, '0, 1'b0, '0, 1'b1));
                end else begin
                    tail = timer_answer_q.pop_back();
                    tail.last = 1'b1;
                    timer_answer_q.push_back(tail);
                end
            end
            default: begin
                // ignored kind: no state change, no answer
            end
        endcase
    endtask

    task automatic queue_req(logic [1:0] kind, logic [63:0] now_ms,
                             logic [15:0] service_id, logic [30:0] interval_ms);
        timer_req_t rq;
        rq.kind        = kind;
        rq.now_ms      = now_ms;
        rq.service_id  = service_id;
        rq.interval_ms = interval_ms;
        timer_req_q.push_back(rq);
    endtask

    // Mostly short idle stretches, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive requests at the falling edge; hold until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (timer_req_q.size() != 0) begin
                drv_req = timer_req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, drv_req.interval_ms, drv_req.service_id, drv_req.now_ms};
                s_tuser  <= drv_req.kind;
                if ($urandom_range(0, 99) < 4) s_burst = ~s_burst;
                s_gap = s_burst ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Throttle the result side
    always @(negedge aclk) begin
        if ($urandom_range(0, 99) < 2) m_burst = ~m_burst;
        if (m_stall > 0) begin
            m_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!m_burst && $urandom_range(0, 99) < 15) m_stall = pick_gap();
        end
    end

    // Sample both handshakes at the rising edge
    always @(posedge aclk) begin
        timer_answer_t want;
        cycle_cnt++;
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) timer_table_step(drv_req);
        if (aresetn && m_tvalid && m_tready) begin
            if (timer_answer_q.size() == 0) begin
                $error("unexpected answer: tdata %h tlast %b", m_tdata, m_tlast);
                fail_cnt++;
            end else begin
                want = timer_answer_q.pop_front();
                if (m_tdata[0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[0]);
                    fail_cnt++;
                end
                if (m_tdata[32:1] !== want.timeout_ms) begin
                    $error("timeout_ms: expected %0d, got %0d",
                           $signed(want.timeout_ms), $signed(m_tdata[32:1]));
                    fail_cnt++;
                end
                if (m_tdata[33] !== want.fired) begin
                    $error("fired: expected %0d, got %0d", want.fired, m_tdata[33]);
                    fail_cnt++;
                end
                if (m_tdata[49:34] !== want.fired_service) begin
                    $error("fired_service: expected %h, got %h",
                           want.fired_service, m_tdata[49:34]);
                    fail_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [63:0] gen_now;
        int          gen_cnt;
        int          real_cnt;
        int          r;
        logic [30:0] ivl;

        // Empty table, ignored kind, saturation and exact-boundary answers
        queue_req(KIND_QUERY,    64'd0, 16'h1234, 31'd7);
        queue_req(KIND_DISPATCH, 64'd0, 16'h0000, 31'd0);
        queue_req(KIND_IGNORED,  TIME_TOP, 16'hFFFF, IVL_TOP);
        queue_req(KIND_QUERY,    TIME_HIGH, 16'h0000, 31'd0);
        queue_req(KIND_REGISTER, 64'd0, 16'hFFFF, IVL_TOP);
        queue_req(KIND_QUERY,    64'd0, 16'h0000, 31'd0);
        queue_req(KIND_QUERY,    TIME_HIGH, 16'h0000, 31'd0);
        queue_req(KIND_DISPATCH, TIME_HIGH + 64'h7FFF_FFFE, 16'h0000, 31'd0);
        queue_req(KIND_QUERY,    TIME_HIGH + 64'h7FFF_FFFF, 16'h0000, 31'd0);
        queue_req(KIND_DISPATCH, TIME_HIGH + 64'h7FFF_FFFF, 16'h0000, 31'd0);
        // Entry due at the all-ones time, zero interval, then wrap past the top
        queue_req(KIND_QUERY,    TIME_TOP - 64'd100, 16'h0000, 31'd0);
        queue_req(KIND_REGISTER, 64'd0, 16'h5A5A, 31'd100);
        queue_req(KIND_REGISTER, TIME_TOP, 16'h0000, 31'd0);
        queue_req(KIND_DISPATCH, TIME_TOP - 64'd1, 16'h0000, 31'd0);
        queue_req(KIND_DISPATCH, TIME_TOP, 16'h0000, 31'd0);
        queue_req(KIND_QUERY,    64'd1000, 16'h0000, 31'd0);
        queue_req(KIND_REGISTER, 64'd0, 16'hA5A5, 31'd1);
        gen_cnt = 4;
        gen_now = 64'd1000;

        // Random traffic: fill the table early, then mostly query and dispatch
        real_cnt = 0;
        while (real_cnt < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if ((gen_cnt < TIMERS) ? (r < 35) : (r < 6)) begin
                r = $urandom_range(0, 19);
                if (r == 0)      ivl = '0;
                else if (r == 1) ivl = 31'($urandom);
                else if (r == 2) ivl = IVL_TOP;
                else             ivl = 31'($urandom_range(1, 300));
                queue_req(KIND_REGISTER, {$urandom, $urandom}, 16'($urandom), ivl);
                gen_cnt++;
                real_cnt++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    queue_req(KIND_IGNORED, {$urandom, $urandom}, 16'($urandom),
                              31'($urandom));
                end else begin
                    if (r < 8) begin
                        queue_req((r < 6) ? KIND_QUERY : KIND_DISPATCH,
                                  {$urandom, $urandom}, 16'($urandom), 31'($urandom));
                    end else begin
                        if ($urandom_range(0, 9) == 0)
                            gen_now += 64'($urandom_range(200, 2000));
                        else
                            gen_now += 64'($urandom_range(0, 60));
                        queue_req((r < 60) ? KIND_DISPATCH : KIND_QUERY,
                                  gen_now, 16'($urandom), 31'($urandom));
                    end
                    real_cnt++;
                end
            end
        end

        // Release reset at a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain the backlog, then the answers, then let the block settle
        while (timer_req_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (timer_answer_q.size() != 0) @(posedge aclk);
        repeat (TIMERS + 24) @(posedge aclk);
        if (timer_answer_q.size() != 0) begin
            $error("%0d answers never arrived", timer_answer_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
